// ===== rtl/core/slfb_pkg.sv =====
// ----------------------------------------------------------------------------
// slfb_pkg
// Shared types and constants of the stuffed link frame builder: item and
// result payloads, configuration set, job descriptor and sequencer phases.
// ----------------------------------------------------------------------------
package slfb_pkg;

	// register reset values
	localparam logic [7:0] FLAG_RESET    = 8'd126;
	localparam logic [7:0] ESCAPE_RESET  = 8'd125;
	localparam logic [7:0] MASK_RESET    = 8'd32;
	localparam logic [7:0] ADDRESS_RESET = 8'd3;

	// depth of the job queue between front and back
	localparam int SLFB_JOB_DEPTH = 2;

	// apb geometry
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	// register indexes
	typedef enum logic [1:0] {
		REG_FLAG    = 2'd0,
		REG_ESCAPE  = 2'd1,
		REG_MASK    = 2'd2,
		REG_ADDRESS = 2'd3
	} reg_idx_t;

	// input actions
	localparam logic ACT_PAYLOAD     = 1'b0;
	localparam logic ACT_SUPERVISION = 1'b1;

	typedef struct packed {
		logic       action;
		logic       first_byte;
		logic       last_byte;
		logic [7:0] payload_byte;
		logic [7:0] control_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       frame_end;
	} result_t;

	typedef struct packed {
		logic [7:0] flag_value;
		logic [7:0] escape_value;
		logic [7:0] stuff_mask;
		logic [7:0] address_value;
	} cfg_t;

	// one unit of work for the back part
	typedef struct packed {
		logic       sup;     // supervision frame
		logic       hdr;     // header goes out first
		logic       last;    // bcc2 and closing flag follow the data byte
		logic [7:0] ctrl;
		logic [7:0] data;
		logic [7:0] bcc;     // running xor including this data byte
	} job_t;

	// queue head as seen by the back part
	typedef struct packed {
		logic valid;
		job_t job;
	} job_head_t;

	typedef enum logic [3:0] {
		PH_START,
		PH_FLAG_OPEN,
		PH_ADDR,
		PH_CTRL,
		PH_BCC1,
		PH_DATA,
		PH_DATA_ESC,
		PH_BCC2,
		PH_BCC2_ESC,
		PH_FLAG_CLOSE
	} phase_t;

endpackage

// ===== rtl/core/slfb_front.sv =====
// ----------------------------------------------------------------------------
// slfb_front
// Classifies accepted items, keeps the running bcc2 and frame state, and
// turns every item that produces bytes into one job for the back part.
// ----------------------------------------------------------------------------
module slfb_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  slfb_pkg::item_t item,
	output logic           job_push,
	output slfb_pkg::job_t job
);
	import slfb_pkg::*;

	logic [7:0] parity_q;
	logic       in_frame_q;
	logic [7:0] par_base;
	logic [7:0] par_new;
	logic       open_ok;

	// frame state and running parity as this item sees them
	always_comb begin
		par_base = item.first_byte ? 8'd0 : parity_q;
		par_new  = par_base ^ item.payload_byte;
		open_ok  = item.first_byte || in_frame_q;
	end

	// job descriptor
	always_comb begin
		job.sup  = (item.action == ACT_SUPERVISION);
		job.hdr  = (item.action == ACT_SUPERVISION) || item.first_byte;
		job.last = item.last_byte;
		job.ctrl = item.control_byte;
		job.data = item.payload_byte;
		job.bcc  = par_new;
		job_push = accept && ((item.action == ACT_SUPERVISION) || open_ok);
	end

	// frame state update, supervision leaves it alone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q   <= 8'd0;
			in_frame_q <= 1'b0;
		end else if (accept && (item.action == ACT_PAYLOAD) && open_ok) begin
			if (item.last_byte) begin
				parity_q   <= 8'd0;
				in_frame_q <= 1'b0;
			end else begin
				parity_q   <= par_new;
				in_frame_q <= 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/slfb_job_queue.sv =====
// ----------------------------------------------------------------------------
// slfb_job_queue
// Short first-in first-out queue of jobs between front and back.
// ----------------------------------------------------------------------------
module slfb_job_queue #(
	parameter int DEPTH = slfb_pkg::SLFB_JOB_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  slfb_pkg::job_t       wr_job,
	input  logic                 rd_en,
	output slfb_pkg::job_head_t  head,
	output logic                 full
);
	import slfb_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	// status and head
	always_comb begin
		full       = (count_q == CNT_W'(DEPTH));
		head.valid = (count_q != '0);
		head.job   = slot_q[rd_ptr_q];
		do_wr      = wr_en && !full;
		do_rd      = rd_en && head.valid;
	end

	// slot storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/slfb_back.sv =====
// ----------------------------------------------------------------------------
// slfb_back
// Byte sequencer: walks the head job through header, stuffed data, stuffed
// bcc2 and closing flag, one line byte per cycle unless the output is held.
// ----------------------------------------------------------------------------
module slfb_back (
	input  logic                clk,
	input  logic                arst_n,
	input  slfb_pkg::cfg_t      cfg,
	input  slfb_pkg::job_head_t head,
	output logic                job_pop,
	input  logic                pop,
	output logic                empty,
	output slfb_pkg::result_t   result
);
	import slfb_pkg::*;

	phase_t  phase_q;
	phase_t  phase;
	phase_t  phase_nxt;
	logic    done;
	logic    advance;
	logic    out_valid_q;
	result_t out_q;
	result_t out_nxt;
	logic    data_hit;
	logic    bcc_hit;

	// bytes that need an escape
	always_comb begin
		data_hit = (head.job.data == cfg.flag_value) || (head.job.data == cfg.escape_value);
		bcc_hit  = (head.job.bcc == cfg.flag_value) || (head.job.bcc == cfg.escape_value);
	end

	// current byte and next phase
	always_comb begin
		if (phase_q == PH_START) begin
			phase = head.job.hdr ? PH_FLAG_OPEN : PH_DATA;
		end else begin
			phase = phase_q;
		end
		out_nxt.out_byte  = cfg.flag_value;
		out_nxt.frame_end = 1'b0;
		phase_nxt         = PH_START;
		done              = 1'b0;
		case (phase)
			PH_FLAG_OPEN: begin
				out_nxt.out_byte = cfg.flag_value;
				phase_nxt        = PH_ADDR;
			end
			PH_ADDR: begin
				out_nxt.out_byte = cfg.address_value;
				phase_nxt        = PH_CTRL;
			end
			PH_CTRL: begin
				out_nxt.out_byte = head.job.ctrl;
				phase_nxt        = PH_BCC1;
			end
			PH_BCC1: begin
				out_nxt.out_byte = cfg.address_value ^ head.job.ctrl;
				phase_nxt        = head.job.sup ? PH_FLAG_CLOSE : PH_DATA;
			end
			PH_DATA: begin
				if (data_hit) begin
					out_nxt.out_byte = cfg.escape_value;
					phase_nxt        = PH_DATA_ESC;
				end else begin
					out_nxt.out_byte = head.job.data;
					phase_nxt        = head.job.last ? PH_BCC2 : PH_START;
					done             = !head.job.last;
				end
			end
			PH_DATA_ESC: begin
				out_nxt.out_byte = head.job.data ^ cfg.stuff_mask;
				phase_nxt        = head.job.last ? PH_BCC2 : PH_START;
				done             = !head.job.last;
			end
			PH_BCC2: begin
				if (bcc_hit) begin
					out_nxt.out_byte = cfg.escape_value;
					phase_nxt        = PH_BCC2_ESC;
				end else begin
					out_nxt.out_byte = head.job.bcc;
					phase_nxt        = PH_FLAG_CLOSE;
				end
			end
			PH_BCC2_ESC: begin
				out_nxt.out_byte = head.job.bcc ^ cfg.stuff_mask;
				phase_nxt        = PH_FLAG_CLOSE;
			end
			PH_FLAG_CLOSE: begin
				out_nxt.out_byte  = cfg.flag_value;
				out_nxt.frame_end = 1'b1;
				phase_nxt         = PH_START;
				done              = 1'b1;
			end
			default: begin
				phase_nxt = PH_START;
			end
		endcase
		out_nxt.run_last = done;
		advance          = head.valid && (!out_valid_q || pop);
		job_pop          = advance && done;
	end

	// phase register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
		end else if (advance) begin
			phase_q <= phase_nxt;
		end
	end

	// output register, refilled when empty or in the cycle of a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			out_valid_q <= head.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= out_nxt;
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

endmodule

// ===== rtl/core/stuffed_link_frame_builder.sv =====
// ----------------------------------------------------------------------------
// stuffed_link_frame_builder
// Byte-stuffing link framer with xor block check bytes.
// ----------------------------------------------------------------------------
// Input items enter through push/full; a transfer happens when push is high
// and full is low. Line bytes leave through empty/pop; the oldest byte sits
// on result while empty is low and moves on a cycle with pop high.
// An APB port sets flag, escape, stuff mask and address (byte offsets 0, 4,
// 8, 12); write it only while the framer is idle.
// The first byte of an item passes through the job queue and the output
// register. The back sequencer sends one line byte per cycle while pop keeps
// the output free; an item makes 1 line byte for a plain payload byte, 2 for a
// stuffed one, up to 9 for a one-byte frame with header and stuffed bcc2, and
// 5 for a supervision frame. Payload without an open frame makes no bytes.
// A job queue of JOB_DEPTH entries decouples input from the sequencer, so
// items keep arriving while a longer item is still being sent.
// Reset returns the registers to their defaults, closes any open frame and
// empties the job queue and output register.
// When pop stays low the output byte holds, the sequencer waits, the queue
// fills and full rises.
// ----------------------------------------------------------------------------
module stuffed_link_frame_builder #(
	parameter int JOB_DEPTH = slfb_pkg::SLFB_JOB_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  slfb_pkg::item_t                    item,
	output logic                               empty,
	input  logic                               pop,
	output slfb_pkg::result_t                  result,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [slfb_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [slfb_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [slfb_pkg::APB_DATA_W-1:0]    prdata,
	output logic                               pready
);
	import slfb_pkg::*;

	cfg_t      cfg_q;
	reg_idx_t  reg_idx;
	logic      accept;
	logic      job_push;
	job_t      job;
	job_head_t head;
	logic      job_pop;

	// configuration registers
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flag_value    <= FLAG_RESET;
			cfg_q.escape_value  <= ESCAPE_RESET;
			cfg_q.stuff_mask    <= MASK_RESET;
			cfg_q.address_value <= ADDRESS_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_FLAG:    cfg_q.flag_value    <= pwdata[7:0];
				REG_ESCAPE:  cfg_q.escape_value  <= pwdata[7:0];
				REG_MASK:    cfg_q.stuff_mask    <= pwdata[7:0];
				REG_ADDRESS: cfg_q.address_value <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// register read back
	always_comb begin
		case (reg_idx)
			REG_FLAG:    prdata = APB_DATA_W'(cfg_q.flag_value);
			REG_ESCAPE:  prdata = APB_DATA_W'(cfg_q.escape_value);
			REG_MASK:    prdata = APB_DATA_W'(cfg_q.stuff_mask);
			REG_ADDRESS: prdata = APB_DATA_W'(cfg_q.address_value);
			default:     prdata = '0;
		endcase
	end

	// input transfer
	assign accept = push && !full;

	slfb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.job_push (job_push),
		.job      (job)
	);

	slfb_job_queue #(
		.DEPTH (JOB_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (job_push),
		.wr_job (job),
		.rd_en  (job_pop),
		.head   (head),
		.full   (full)
	);

	slfb_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.head    (head),
		.job_pop (job_pop),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

endmodule

// ===== rtl/core/slfb_checker.sv =====
// ----------------------------------------------------------------------------
// slfb_checker
// Port-level checks of the frame builder, bound to the top level.
// ----------------------------------------------------------------------------
module slfb_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              full,
	input logic              empty,
	input logic              pop,
	input slfb_pkg::result_t result
);
	import slfb_pkg::*;

	// a closing flag always ends the bytes of its item
	a_close_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.frame_end) |-> result.run_last)
		else $error("closing flag without run_last");

	// right out of reset nothing waits and the queue takes items
	a_reset_clean: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> (empty && !full))
		else $error("framer not clean after reset");

	// a waiting byte stays until transferred
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("result dropped without transfer");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> $stable(result))
		else $error("stalled result changed");

endmodule

bind stuffed_link_frame_builder slfb_checker u_slfb_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.full   (full),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stuffed link frame builder. Queued items are
// pushed with random gaps, or back to back in one phase. Every accepted
// item is framed by a local model of the framer, and each popped line byte
// is checked against the oldest byte still due. The APB registers are
// rewritten between traffic phases while the framer is idle.
// ----------------------------------------------------------------------------
module tb;
	import slfb_pkg::*;

	localparam int DRAIN_CYCLES = 16;
	localparam int STALL_LIMIT  = 5000;
	localparam int SHOWN_ERRORS = 10;
	localparam int ITEM_W       = $bits(item_t);

	logic                  clk     = 1'b0;
	logic                  arst_n  = 1'b0;
	logic                  push    = 1'b0;
	logic                  full;
	item_t                 item    = '0;
	logic                  empty;
	logic                  pop     = 1'b0;
	result_t               result;
	logic                  psel    = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite  = 1'b0;
	logic [APB_ADDR_W-1:0] paddr   = '0;
	logic [APB_DATA_W-1:0] pwdata  = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	// stimulus and expectation stores
	item_t   items_to_send[$];
	result_t line_bytes_due[$];
	result_t frame_burst[$];

	// local copy of the framer registers and frame state
	cfg_t       line_cfg;
	logic [7:0] bcc_run;
	logic       frame_open;

	int  error_count = 0;
	int  quiet_cycles = 0;
	bit  steady = 1'b0;

	stuffed_link_frame_builder uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.empty   (empty),
		.pop     (pop),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void note_error(input string msg);
		error_count++;
		if (error_count <= SHOWN_ERRORS)
			$display("%t mismatch: %s", $realtime, msg);
	endfunction

	// framing model
	function automatic void emit(input logic [7:0] b, input logic closing);
		result_t r;
		r.out_byte  = b;
		r.run_last  = 1'b0;
		r.frame_end = closing;
		frame_burst.push_back(r);
	endfunction

	function automatic void emit_stuffed(input logic [7:0] b);
		if (b == line_cfg.flag_value || b == line_cfg.escape_value) begin
			emit(line_cfg.escape_value, 1'b0);
			emit(b ^ line_cfg.stuff_mask, 1'b0);
		end else begin
			emit(b, 1'b0);
		end
	endfunction

	function automatic void emit_header(input logic [7:0] ctrl);
		emit(line_cfg.flag_value, 1'b0);
		emit(line_cfg.address_value, 1'b0);
		emit(ctrl, 1'b0);
		emit(line_cfg.address_value ^ ctrl, 1'b0);
	endfunction

	function automatic void frame_bytes_for(input item_t it);
		result_t r;
		frame_burst.delete();
		if (it.action == ACT_SUPERVISION) begin
			emit_header(it.control_byte);
			emit(line_cfg.flag_value, 1'b1);
		end else begin
			if (it.first_byte) begin
				emit_header(it.control_byte);
				bcc_run    = 8'h00;
				frame_open = 1'b1;
			end
			if (frame_open) begin
				emit_stuffed(it.payload_byte);
				bcc_run = bcc_run ^ it.payload_byte;
				if (it.last_byte) begin
					emit_stuffed(bcc_run);
					emit(line_cfg.flag_value, 1'b1);
					bcc_run    = 8'h00;
					frame_open = 1'b0;
				end
			end
		end
		if (frame_burst.size() > 0) begin
			r = frame_burst.pop_back();
			r.run_last = 1'b1;
			frame_burst.push_back(r);
		end
		foreach (frame_burst[k])
			line_bytes_due.push_back(frame_burst[k]);
	endfunction

	// input side: present queued items, predict on each transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				frame_bytes_for(item);
			if (!push || !full) begin
				if (items_to_send.size() > 0 && (steady || $urandom_range(99) >= 24)) begin
					push <= 1'b1;
					item <= items_to_send.pop_front();
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// output side: random pop, check each transfer against the oldest due byte
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (line_bytes_due.size() == 0) begin
					note_error($sformatf("unexpected byte %h run_last %b frame_end %b",
						result.out_byte, result.run_last, result.frame_end));
				end else begin
					want = line_bytes_due.pop_front();
					if (result.out_byte !== want.out_byte ||
					    result.run_last !== want.run_last ||
					    result.frame_end !== want.frame_end)
						note_error($sformatf(
							"out_byte exp %h got %h, run_last exp %b got %b, frame_end exp %b got %b",
							want.out_byte, result.out_byte, want.run_last, result.run_last,
							want.frame_end, result.frame_end));
				end
			end
			pop <= steady || $urandom_range(99) >= 24;
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[stuffed_link_frame_builder] ERROR");
			$finish;
		end
	end

	task automatic reg_write(input reg_idx_t idx, input logic [7:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {24'h0, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_FLAG:    line_cfg.flag_value    = val;
			REG_ESCAPE:  line_cfg.escape_value  = val;
			REG_MASK:    line_cfg.stuff_mask    = val;
			REG_ADDRESS: line_cfg.address_value = val;
			default: begin
			end
		endcase
	endtask

	task automatic write_all(input logic [7:0] f, input logic [7:0] e,
	                         input logic [7:0] m, input logic [7:0] a);
		reg_write(REG_FLAG, f);
		reg_write(REG_ESCAPE, e);
		reg_write(REG_MASK, m);
		reg_write(REG_ADDRESS, a);
	endtask

	// wait until every queued item is sent and every due byte has come
	task automatic wait_idle();
		do @(posedge clk);
		while (items_to_send.size() != 0 || push || line_bytes_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic void queue_item(input logic act, input logic first, input logic last,
	                                   input logic [7:0] data, input logic [7:0] ctrl);
		item_t it;
		it.action       = act;
		it.first_byte   = first;
		it.last_byte    = last;
		it.payload_byte = data;
		it.control_byte = ctrl;
		items_to_send.push_back(it);
	endfunction

	// payload biased toward the bytes that need stuffing
	function automatic logic [7:0] pick_byte();
		int roll;
		roll = $urandom_range(99);
		if (roll < 15)
			return line_cfg.flag_value;
		else if (roll < 30)
			return line_cfg.escape_value;
		return 8'($urandom);
	endfunction

	// mostly well-formed frames with random content, some noise
	task automatic queue_traffic(input int count);
		int    left;
		int    len;
		item_t it;
		left = count;
		while (left > 0) begin
			if ($urandom_range(99) < 80) begin
				len = $urandom_range(1, 6);
				for (int k = 0; k < len; k++) begin
					if ($urandom_range(99) < 8)
						queue_item(ACT_SUPERVISION, 1'($urandom), 1'($urandom),
							8'($urandom), 8'($urandom));
					queue_item(ACT_PAYLOAD, k == 0, k == len - 1, pick_byte(),
						8'($urandom));
					left--;
				end
			end else begin
				it = ITEM_W'($urandom);
				items_to_send.push_back(it);
				left--;
			end
		end
	endtask

	initial begin
		line_cfg.flag_value    = FLAG_RESET;
		line_cfg.escape_value  = ESCAPE_RESET;
		line_cfg.stuff_mask    = MASK_RESET;
		line_cfg.address_value = ADDRESS_RESET;
		bcc_run    = 8'h00;
		frame_open = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset registers
		queue_item(ACT_SUPERVISION, 1'b0, 1'b0, 8'h00, 8'h00);
		queue_item(ACT_SUPERVISION, 1'b1, 1'b1, 8'hFF, 8'hFF);
		// payload with no open frame is dropped
		queue_item(ACT_PAYLOAD, 1'b0, 1'b1, 8'h7E, 8'h11);
		queue_item(ACT_PAYLOAD, 1'b0, 1'b0, 8'h42, 8'h22);
		// one-byte frame, payload and bcc2 both stuffed
		queue_item(ACT_PAYLOAD, 1'b1, 1'b1, 8'h7E, 8'h7D);
		// longer frame with supervision in the middle
		queue_item(ACT_PAYLOAD, 1'b1, 1'b0, 8'h00, 8'hFF);
		queue_item(ACT_PAYLOAD, 1'b0, 1'b0, 8'hFF, 8'h00);
		queue_item(ACT_PAYLOAD, 1'b0, 1'b0, 8'h7D, 8'h00);
		queue_item(ACT_SUPERVISION, 1'b0, 1'b0, 8'h00, 8'h7E);
		queue_item(ACT_PAYLOAD, 1'b0, 1'b0, 8'h7E, 8'h00);
		queue_item(ACT_PAYLOAD, 1'b0, 1'b1, 8'h55, 8'h00);
		// new first byte abandons the open frame
		queue_item(ACT_PAYLOAD, 1'b1, 1'b0, 8'h31, 8'h08);
		queue_item(ACT_PAYLOAD, 1'b1, 1'b0, 8'h10, 8'h09);
		// bcc2 lands on the escape byte
		queue_item(ACT_PAYLOAD, 1'b0, 1'b1, 8'h6D, 8'h00);
		wait_idle();

		// flag equal to escape, full mask, zero address
		write_all(8'h55, 8'h55, 8'hFF, 8'h00);
		queue_item(ACT_PAYLOAD, 1'b1, 1'b0, 8'h55, 8'h55);
		queue_item(ACT_PAYLOAD, 1'b0, 1'b1, 8'hAA, 8'h00);
		queue_item(ACT_SUPERVISION, 1'b0, 1'b0, 8'h00, 8'h55);
		queue_traffic(75);
		wait_idle();

		// opposite extremes, with no idling on either side
		write_all(8'h00, 8'hFF, 8'h00, 8'hFF);
		steady = 1'b1;
		queue_traffic(75);
		wait_idle();
		steady = 1'b0;

		// random registers, sender holds off halfway until the line drains
		write_all(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		queue_traffic(40);
		wait_idle();
		queue_traffic(40);
		wait_idle();

		// back to the defaults
		write_all(FLAG_RESET, ESCAPE_RESET, MASK_RESET, ADDRESS_RESET);
		queue_traffic(75);
		wait_idle();

		if (line_bytes_due.size() != 0)
			note_error($sformatf("%0d line bytes never came", line_bytes_due.size()));
		if (error_count == 0)
			$display("[stuffed_link_frame_builder] OK");
		else
			$display("[stuffed_link_frame_builder] ERROR");
		$finish;
	end

endmodule
